/* src/jan_pkg.sv */
// jan_pkg: shared widths, constants and register indexes for the joystick axis normalizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jan_pkg;

    // sample and lane sizing
    localparam int SAMPLE_WIDTH = 12;
    localparam int NUM_STICKS   = 4;

    // quotient bits kept by the divider (span of 1000 fits in 10 bits)
    localparam int QUOT_W = 10;
    localparam int DIV_W  = SAMPLE_WIDTH + QUOT_W;

    // register and field widths
    localparam int CALIB_W    = 2 * SAMPLE_WIDTH;
    localparam int DZ_W       = 9;
    localparam int CFG_W      = (CALIB_W > DZ_W) ? CALIB_W : DZ_W;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 11;
    localparam int BATT_W     = 7;

    // pipeline depth: edges from input acceptance to result acceptance
    localparam int PIPE_LATENCY = QUOT_W + 2;

    // position scale
    localparam logic [POS_W-1:0]  POS_MIN    = 11'd1000;
    localparam logic [POS_W-1:0]  POS_MAX    = 11'd2000;
    localparam logic [POS_W-1:0]  POS_CENTRE = 11'd1500;
    localparam logic [QUOT_W-1:0] POS_SPAN   = 10'd1000;

    // battery scale: 3.3 V full scale times 20
    localparam logic [BATT_W-1:0] BATT_SCALE = 7'd66;
    localparam logic [BATT_W-1:0] BATT_MAX   = 7'd65;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIB_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIB_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIB_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIB_CH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD_ZONE = 3'd4;

    // reset values of the configuration registers
    localparam logic [CALIB_W-1:0] CALIB_RST [NUM_STICKS] = '{
        CALIB_W'(24'd15245518),
        CALIB_W'(24'd15307004),
        CALIB_W'(24'd15597919),
        CALIB_W'(24'd15982924)
    };
    localparam logic [DZ_W-1:0] DZ_RST = 9'd100;

endpackage

/* src/joystick_axis_normalizer_unit.sv */
// joystick_axis_normalizer_unit: four axis lanes, battery path and result merge register
// depends on jan_pkg, jan_axis_lane, jan_battery_path
// an accepted scan passes the front stage, 10 divider stages and the merge register to its result
// throughput: one scan per cycle, busy stays low; each lane's pipelined divider sets the depth
// reset: rst_n clears the pipeline valid line and the strobe and restores the calibration
//   and dead zone registers; no results are lost because the receiver cannot stall
`timescale 1ns / 1ps

module joystick_axis_normalizer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw_ch0,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw_ch1,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw_ch2,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw_ch3,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw_battery,
    output logic                             done,
    output logic [jan_pkg::POS_W-1:0]        pos_ch0,
    output logic [jan_pkg::POS_W-1:0]        pos_ch1,
    output logic [jan_pkg::POS_W-1:0]        pos_ch2,
    output logic [jan_pkg::POS_W-1:0]        pos_ch3,
    output logic [jan_pkg::BATT_W-1:0]       battery_level,
    input  logic                             cfg_we,
    input  logic [jan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jan_pkg::CFG_W-1:0]        cfg_wdata
);

    import jan_pkg::*;

    logic                    accept;
    logic [CALIB_W-1:0]      calib_reg [NUM_STICKS];
    logic [DZ_W-1:0]         dz_reg;
    logic [QUOT_W:0]         valid_reg;
    logic [QUOT_W:0]         valid_next;
    logic                    done_reg;
    logic [SAMPLE_WIDTH-1:0] raw_lane [NUM_STICKS];
    logic [POS_W-1:0]        pos_lane [NUM_STICKS];
    logic [BATT_W-1:0]       batt_level;
    logic [POS_W-1:0]        pos_out_reg [NUM_STICKS];
    logic [BATT_W-1:0]       batt_out_reg;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STICKS; i++)
            begin
                calib_reg[i] <= CALIB_RST[i];
            end
            dz_reg <= DZ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_CALIB_CH0: calib_reg[0] <= cfg_wdata[CALIB_W-1:0];
                CFG_IDX_CALIB_CH1: calib_reg[1] <= cfg_wdata[CALIB_W-1:0];
                CFG_IDX_CALIB_CH2: calib_reg[2] <= cfg_wdata[CALIB_W-1:0];
                CFG_IDX_CALIB_CH3: calib_reg[3] <= cfg_wdata[CALIB_W-1:0];
                CFG_IDX_DEAD_ZONE: dz_reg       <= cfg_wdata[DZ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // valid line alongside the lane pipelines
    assign valid_next = {valid_reg[QUOT_W-1:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[QUOT_W];
        end
    end

    // axis lanes
    assign raw_lane[0] = raw_ch0;
    assign raw_lane[1] = raw_ch1;
    assign raw_lane[2] = raw_ch2;
    assign raw_lane[3] = raw_ch3;

    genvar l;
    generate
        for (l = 0; l < NUM_STICKS; l++)
        begin : g_lane
            jan_axis_lane u_lane
            (
                .clk       (clk),
                .raw       (raw_lane[l]),
                .calib     (calib_reg[l]),
                .dead_zone (dz_reg),
                .pos       (pos_lane[l])
            );
        end
    endgenerate

    // battery path
    jan_battery_path u_battery
    (
        .clk   (clk),
        .raw   (raw_battery),
        .level (batt_level)
    );

    // merge stage: one result register for all lanes and the battery
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STICKS; i++)
        begin
            pos_out_reg[i] <= pos_lane[i];
        end
        batt_out_reg <= batt_level;
    end

    assign done          = done_reg;
    assign pos_ch0       = pos_out_reg[0];
    assign pos_ch1       = pos_out_reg[1];
    assign pos_ch2       = pos_out_reg[2];
    assign pos_ch3       = pos_out_reg[3];
    assign battery_level = batt_out_reg;

    // every accepted scan gives its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LATENCY done)
        else $error("result strobe missing after scan transaction");

    // positions stay inside the normalized range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pos_ch0 >= POS_MIN && pos_ch0 <= POS_MAX &&
                  pos_ch1 >= POS_MIN && pos_ch1 <= POS_MAX &&
                  pos_ch2 >= POS_MIN && pos_ch2 <= POS_MAX &&
                  pos_ch3 >= POS_MIN && pos_ch3 <= POS_MAX))
        else $error("position out of range");

    // battery level never exceeds full scale
    a_batt_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (battery_level <= BATT_MAX))
        else $error("battery level out of range");

endmodule

/* src/jan_axis_lane.sv */
// jan_axis_lane: one stick channel, scale against calibration through a pipelined divider
// depends on jan_pkg
`timescale 1ns / 1ps

module jan_axis_lane
(
    input  logic                          clk,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw,
    input  logic [jan_pkg::CALIB_W-1:0]   calib,
    input  logic [jan_pkg::DZ_W-1:0]      dead_zone,
    output logic [jan_pkg::POS_W-1:0]     pos
);

    import jan_pkg::*;

    logic [SAMPLE_WIDTH-1:0] lo;
    logic [SAMPLE_WIDTH-1:0] hi;
    logic [SAMPLE_WIDTH-1:0] delta;
    logic [SAMPLE_WIDTH-1:0] divisor;
    logic                    empty;
    logic [DIV_W-1:0]        product;

    // per-stage pipeline registers, stage 0 holds the scaled distance
    logic [DIV_W-1:0]        rem_reg   [QUOT_W+1];
    logic [SAMPLE_WIDTH-1:0] dvs_reg   [QUOT_W+1];
    logic [QUOT_W-1:0]       quo_reg   [QUOT_W+1];
    logic                    sat_reg   [QUOT_W+1];
    logic                    empty_reg [QUOT_W+1];

    logic [POS_W-1:0] sum;
    logic [POS_W-1:0] clamped;
    logic [POS_W-1:0] off;

    // calibration split, distance from minimum and span
    always_comb
    begin
        lo      = calib[SAMPLE_WIDTH-1:0];
        hi      = calib[CALIB_W-1:SAMPLE_WIDTH];
        empty   = (hi <= lo);
        delta   = (raw >= lo) ? (raw - lo) : (lo - raw);
        divisor = hi - lo;
        product = DIV_W'(delta) * DIV_W'(POS_SPAN);
    end

    // front stage: distance times span
    always_ff @(posedge clk)
    begin
        rem_reg[0]   <= product;
        dvs_reg[0]   <= divisor;
        quo_reg[0]   <= '0;
        sat_reg[0]   <= 1'b0;
        empty_reg[0] <= empty;
    end

    // restoring divider, one quotient bit per stage, msb first
    genvar s;
    generate
        for (s = 1; s <= QUOT_W; s++)
        begin : g_div
            localparam int BIT = QUOT_W - s;
            logic [DIV_W-1:0]  trial;
            logic              fits;
            logic              sat_in;
            logic [QUOT_W-1:0] quo_next;

            assign trial = {{QUOT_W{1'b0}}, dvs_reg[s-1]} << BIT;
            assign fits  = (rem_reg[s-1] >= trial);

            // quotient at or above 2^QUOT_W saturates the position
            if (s == 1)
            begin : g_sat
                assign sat_in = (rem_reg[0] >= {dvs_reg[0], {QUOT_W{1'b0}}});
            end
            else
            begin : g_pass
                assign sat_in = sat_reg[s-1];
            end

            always_comb
            begin
                quo_next      = quo_reg[s-1];
                quo_next[BIT] = fits;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]   <= fits ? (rem_reg[s-1] - trial) : rem_reg[s-1];
                dvs_reg[s]   <= dvs_reg[s-1];
                quo_reg[s]   <= quo_next;
                sat_reg[s]   <= sat_in;
                empty_reg[s] <= empty_reg[s-1];
            end
        end
    endgenerate

    // offset, clamp, dead zone snap and empty calibration
    always_comb
    begin
        sum     = POS_W'(quo_reg[QUOT_W]) + POS_MIN;
        clamped = (sat_reg[QUOT_W] || (sum > POS_MAX)) ? POS_MAX : sum;
        off     = (clamped >= POS_CENTRE) ? (clamped - POS_CENTRE) : (POS_CENTRE - clamped);
        if (empty_reg[QUOT_W] || (off < POS_W'(dead_zone)))
        begin
            pos = POS_CENTRE;
        end
        else
        begin
            pos = clamped;
        end
    end

endmodule

/* src/jan_battery_path.sv */
// jan_battery_path: battery scaling and delay line aligned with the axis lanes
// depends on jan_pkg
`timescale 1ns / 1ps

module jan_battery_path
(
    input  logic                             clk,
    input  logic [jan_pkg::SAMPLE_WIDTH-1:0] raw,
    output logic [jan_pkg::BATT_W-1:0]       level
);

    import jan_pkg::*;

    logic [SAMPLE_WIDTH+BATT_W-1:0] product;
    logic [BATT_W-1:0]              lvl_reg [QUOT_W+1];

    // raw times scale, keep the bits above the sample width
    assign product = (SAMPLE_WIDTH + BATT_W)'(raw) * (SAMPLE_WIDTH + BATT_W)'(BATT_SCALE);

    always_ff @(posedge clk)
    begin
        lvl_reg[0] <= product[SAMPLE_WIDTH+BATT_W-1:SAMPLE_WIDTH];
    end

    // delay line matching the divider depth
    genvar s;
    generate
        for (s = 1; s <= QUOT_W; s++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                lvl_reg[s] <= lvl_reg[s-1];
            end
        end
    endgenerate

    assign level = lvl_reg[QUOT_W];

endmodule

/* test/joystick_axis_normalizer_unit_tb.sv */
// joystick_axis_normalizer_unit_tb: self-checking bench that scores every scan transaction against
// an internal scaling and dead zone predictor or a directed table value over several calibration settings
// depends on jan_pkg and joystick_axis_normalizer_unit
`timescale 1ns / 1ps

module joystick_axis_normalizer_unit_tb;

    import jan_pkg::*;

    localparam int SAMPLE_MAX  = (1 << SAMPLE_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 10;

    // register indexes past the dead zone are decoded as nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST = CFG_IDX_DEAD_ZONE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LAST  = '1;

    typedef struct packed {
        logic [0:NUM_STICKS-1][SAMPLE_WIDTH-1:0] raw;
        logic [SAMPLE_WIDTH-1:0]                 batt;
    } scan_t;

    typedef struct packed {
        logic [0:NUM_STICKS-1][POS_W-1:0] pos;
        logic [BATT_W-1:0]                level;
    } reading_t;

    typedef struct {
        scan_t    scan;
        bit       typed;
        reading_t want;
    } scan_row_t;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic [SAMPLE_WIDTH-1:0] raw_ch0     = '0;
    logic [SAMPLE_WIDTH-1:0] raw_ch1     = '0;
    logic [SAMPLE_WIDTH-1:0] raw_ch2     = '0;
    logic [SAMPLE_WIDTH-1:0] raw_ch3     = '0;
    logic [SAMPLE_WIDTH-1:0] raw_battery = '0;
    logic                    done;
    logic [POS_W-1:0]        pos_ch0;
    logic [POS_W-1:0]        pos_ch1;
    logic [POS_W-1:0]        pos_ch2;
    logic [POS_W-1:0]        pos_ch3;
    logic [BATT_W-1:0]       battery_level;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_W-1:0]        cfg_wdata   = '0;

    // predictor copy of the registers, loaded with the reset values
    logic [CALIB_W-1:0] calib_copy [NUM_STICKS] = '{
        24'd15245518, 24'd15307004, 24'd15597919, 24'd15982924
    };
    logic [DZ_W-1:0]    dz_copy = 9'd100;

    // settings staged for the next register load
    logic [CALIB_W-1:0] next_calib [NUM_STICKS];
    logic [DZ_W-1:0]    next_dz;

    reading_t pending_readings [$];
    reading_t observed;
    reading_t want_reading;
    int       mismatch_count = 0;
    int       cycle_count    = 0;

    // directed scans under the reset calibration
    scan_row_t directed_rows [13] = '{
        // every stick at its minimum, empty battery
        '{scan: '{raw: '{12'd206, 12'd252, 12'd351, 12'd332}, batt: 12'd0}, typed: 1'b1,
          want: '{pos: '{11'd1000, 11'd1000, 11'd1000, 11'd1000}, level: 7'd0}},
        // full scale everywhere, clamped to the top
        '{scan: '{raw: '{12'd4095, 12'd4095, 12'd4095, 12'd4095}, batt: 12'd4095}, typed: 1'b1,
          want: '{pos: '{11'd2000, 11'd2000, 11'd2000, 11'd2000}, level: 7'd65}},
        // every stick at its maximum, battery at half scale
        '{scan: '{raw: '{12'd3722, 12'd3737, 12'd3808, 12'd3902}, batt: 12'd2048}, typed: 1'b1,
          want: '{pos: '{11'd2000, 11'd2000, 11'd2000, 11'd2000}, level: 7'd33}},
        // below minimum, mirrored distance
        '{scan: '{raw: '{12'd0, 12'd0, 12'd0, 12'd0}, batt: 12'd1}, typed: 1'b0, want: '0},
        // near centre
        '{scan: '{raw: '{12'd1964, 12'd1994, 12'd2079, 12'd2117}, batt: 12'd62},
          typed: 1'b0, want: '0},
        // alternating bit patterns
        '{scan: '{raw: '{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA}, batt: 12'h555},
          typed: 1'b0, want: '0},
        '{scan: '{raw: '{12'h555, 12'h555, 12'h555, 12'h555}, batt: 12'hAAA},
          typed: 1'b0, want: '0},
        // lower edge of the dead zone and one step inside it
        '{scan: '{raw: '{12'd1613, 12'd1646, 12'd1734, 12'd1760}, batt: 12'd2047},
          typed: 1'b0, want: '0},
        '{scan: '{raw: '{12'd1617, 12'd1650, 12'd1738, 12'd1764}, batt: 12'd4032},
          typed: 1'b0, want: '0},
        // upper edge of the dead zone
        '{scan: '{raw: '{12'd2316, 12'd2343, 12'd2425, 12'd2474}, batt: 12'd63},
          typed: 1'b0, want: '0},
        // one below minimum
        '{scan: '{raw: '{12'd205, 12'd251, 12'd350, 12'd331}, batt: 12'd64}, typed: 1'b1,
          want: '{pos: '{11'd1000, 11'd1000, 11'd1000, 11'd1000}, level: 7'd1}},
        // one above maximum
        '{scan: '{raw: '{12'd3723, 12'd3738, 12'd3809, 12'd3903}, batt: 12'd4094}, typed: 1'b1,
          want: '{pos: '{11'd2000, 11'd2000, 11'd2000, 11'd2000}, level: 7'd65}},
        // mixed extremes
        '{scan: '{raw: '{12'd0, 12'd4095, 12'd2048, 12'd1}, batt: 12'd3102},
          typed: 1'b0, want: '0}
    };

    joystick_axis_normalizer_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .raw_ch0       (raw_ch0),
        .raw_ch1       (raw_ch1),
        .raw_ch2       (raw_ch2),
        .raw_ch3       (raw_ch3),
        .raw_battery   (raw_battery),
        .done          (done),
        .pos_ch0       (pos_ch0),
        .pos_ch1       (pos_ch1),
        .pos_ch2       (pos_ch2),
        .pos_ch3       (pos_ch3),
        .battery_level (battery_level),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    assign observed = {pos_ch0, pos_ch1, pos_ch2, pos_ch3, battery_level};

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one stick: distance from minimum scaled to the span, clamped, snapped to centre
    function automatic logic [POS_W-1:0] axis_position(input logic [SAMPLE_WIDTH-1:0] sample,
                                                       input logic [CALIB_W-1:0] cal,
                                                       input logic [DZ_W-1:0] dz);
        int lo;
        int hi;
        int delta;
        int pos;
        int off;
        lo = int'(cal[SAMPLE_WIDTH-1:0]);
        hi = int'(cal[CALIB_W-1:SAMPLE_WIDTH]);
        if (hi <= lo)
            return POS_CENTRE;
        delta = (int'(sample) >= lo) ? int'(sample) - lo : lo - int'(sample);
        pos   = int'(POS_MIN) + (delta * int'(POS_SPAN)) / (hi - lo);
        if (pos > int'(POS_MAX))
            pos = int'(POS_MAX);
        off = (pos >= int'(POS_CENTRE)) ? pos - int'(POS_CENTRE) : int'(POS_CENTRE) - pos;
        if (off < int'(dz))
            pos = int'(POS_CENTRE);
        return POS_W'(pos);
    endfunction

    // full scan under the current register copy
    function automatic reading_t predict_reading(input scan_t s);
        reading_t r;
        for (int ch = 0; ch < NUM_STICKS; ch++)
            r.pos[ch] = axis_position(s.raw[ch], calib_copy[ch], dz_copy);
        r.level = BATT_W'((int'(s.batt) * int'(BATT_SCALE)) >> SAMPLE_WIDTH);
        return r;
    endfunction

    // sample biased towards the calibration points of a channel
    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(input logic [CALIB_W-1:0] cal);
        int lo;
        int hi;
        int v;
        lo = int'(cal[SAMPLE_WIDTH-1:0]);
        hi = int'(cal[CALIB_W-1:SAMPLE_WIDTH]);
        case ($urandom_range(0, 7))
            0: v = lo;
            1: v = hi;
            2: v = lo + int'($urandom_range(0, 8)) - 4;
            3: v = hi + int'($urandom_range(0, 8)) - 4;
            4: v = (lo + hi) / 2 + int'($urandom_range(0, 400)) - 200;
            5: v = ($urandom_range(0, 1) == 0) ? 0 : SAMPLE_MAX;
            default: v = int'($urandom_range(0, SAMPLE_MAX));
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_WIDTH'(v);
    endfunction

    // calibration pair: mostly sane, sometimes tiny, empty or fully random
    function automatic logic [CALIB_W-1:0] pick_calib();
        int lo;
        int hi;
        lo = int'($urandom_range(0, 3000));
        case ($urandom_range(0, 6))
            0: return CALIB_W'($urandom);
            1:
            begin
                lo = int'($urandom_range(0, SAMPLE_MAX));
                hi = int'($urandom_range(0, lo));
            end
            2: hi = lo + int'($urandom_range(1, 3));
            default: hi = int'($urandom_range(lo + 1, SAMPLE_MAX));
        endcase
        return {SAMPLE_WIDTH'(hi), SAMPLE_WIDTH'(lo)};
    endfunction

    // present one scan and hold it until the transaction is taken
    task automatic issue_scan(input scan_t s, input bit typed, input reading_t typed_reading);
        start       <= 1'b1;
        raw_ch0     <= s.raw[0];
        raw_ch1     <= s.raw[1];
        raw_ch2     <= s.raw[2];
        raw_ch3     <= s.raw[3];
        raw_battery <= s.batt;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_readings.push_back(typed ? typed_reading : predict_reading(s));
    endtask

    task automatic pause_scans(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // wait until every scan has returned and the pipeline has emptied
    task automatic settle();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // load the staged settings, then poke an unused index that must change nothing
    task automatic apply_settings();
        for (int ch = 0; ch < NUM_STICKS; ch++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_CALIB_CH0 + CFG_IDX_W'(ch);
            cfg_wdata <= next_calib[ch];
            @(posedge clk);
            calib_copy[ch] = next_calib[ch];
        end
        cfg_index <= CFG_IDX_DEAD_ZONE;
        cfg_wdata <= {(CFG_W - DZ_W)'($urandom), next_dz};
        @(posedge clk);
        dz_copy = next_dz;
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_SPARE_LAST));
        cfg_wdata <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_scans(input int count, input bit steady);
        scan_t s;
        for (int n = 0; n < count; n++)
        begin
            if (!steady && $urandom_range(0, 3) == 0)
                pause_scans($urandom_range(1, 18));
            for (int ch = 0; ch < NUM_STICKS; ch++)
                s.raw[ch] = pick_sample(calib_copy[ch]);
            s.batt = SAMPLE_WIDTH'($urandom);
            issue_scan(s, 1'b0, '0);
        end
    endtask

    // stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            if ($urandom_range(0, 3) == 0)
                pause_scans($urandom_range(1, 18));
            issue_scan(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each under its own register setting
        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            for (int ch = 0; ch < NUM_STICKS; ch++)
                next_calib[ch] = pick_calib();
            next_dz = DZ_W'($urandom_range(0, (1 << DZ_W) - 1));
            case (phase)
                1:
                begin
                    // widest span, no dead zone
                    for (int ch = 0; ch < NUM_STICKS; ch++)
                        next_calib[ch] = {SAMPLE_WIDTH'(SAMPLE_MAX), SAMPLE_WIDTH'(0)};
                    next_dz = '0;
                end
                2: next_dz = '1;
                3:
                begin
                    // equal pair, inverted pair, span of one
                    next_dz       = 9'd500;
                    next_calib[0] = {12'd1800, 12'd1800};
                    next_calib[1] = {12'd1000, 12'd3000};
                    next_calib[2] = {12'd2001, 12'd2000};
                end
                4:
                begin
                    next_calib[0] = '0;
                    next_calib[1] = '0;
                    next_calib[2] = '1;
                    next_calib[3] = '1;
                end
                default: ;
            endcase
            settle();
            apply_settings();
            run_random_scans((phase == 4) ? 20 : 70, (phase == 6) || (phase == NUM_PHASES));
        end

        settle();
        if (mismatch_count == 0)
            $display("joystick_axis_normalizer_unit verification clean");
        else
            $display("joystick_axis_normalizer_unit verification failed");
        $finish;
    end

    // result checking, oldest expectation first
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result transaction with no scan outstanding");
                mismatch_count++;
            end
            else
            begin
                want_reading = pending_readings.pop_front();
                for (int ch = 0; ch < NUM_STICKS; ch++)
                begin
                    if (observed.pos[ch] !== want_reading.pos[ch])
                    begin
                        $error("pos_ch%0d: expected %0d, actual %0d",
                               ch, want_reading.pos[ch], observed.pos[ch]);
                        mismatch_count++;
                    end
                end
                if (observed.level !== want_reading.level)
                begin
                    $error("battery_level: expected %0d, actual %0d",
                           want_reading.level, observed.level);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("joystick_axis_normalizer_unit verification failed");
            $finish;
        end
    end

endmodule

/* joystick_axis_normalizer_unit.f */
src/jan_pkg.sv
src/jan_axis_lane.sv
src/jan_battery_path.sv
src/joystick_axis_normalizer_unit.sv
test/joystick_axis_normalizer_unit_tb.sv
